### sv/bsp_pkg.sv
// ---------------------------------------------------------------------------
// bsp_pkg
// Shared types and constants for the 24-bit BMP stream parser.
// ---------------------------------------------------------------------------
package bsp_pkg;

    // largest accepted image width or height
    localparam int unsigned MAX_DIM = 4096;
    // column and row counters must reach MAX_DIM itself
    localparam int unsigned CNT_W   = $clog2(MAX_DIM + 1);
    localparam logic [31:0] DIM_LIMIT = 32'(MAX_DIM);

    // result kinds
    localparam logic [2:0] KIND_PIXEL   = 3'd0;
    localparam logic [2:0] KIND_HEADER  = 3'd1;
    localparam logic [2:0] KIND_BAD_SIG = 3'd2;
    localparam logic [2:0] KIND_BAD_FMT = 3'd3;
    localparam logic [2:0] KIND_TOO_BIG = 3'd4;

    // header byte positions and expected values
    localparam logic [5:0] HDR_SIG0     = 6'd0;
    localparam logic [5:0] HDR_SIG1     = 6'd1;
    localparam logic [5:0] HDR_WIDTH0   = 6'd18;
    localparam logic [5:0] HDR_WIDTH3   = 6'd21;
    localparam logic [5:0] HDR_HEIGHT0  = 6'd22;
    localparam logic [5:0] HDR_HEIGHT3  = 6'd25;
    localparam logic [5:0] HDR_PLANES   = 6'd26;
    localparam logic [5:0] HDR_BPP      = 6'd28;
    localparam logic [5:0] HDR_COMP0    = 6'd30;
    localparam logic [5:0] HDR_COMP3    = 6'd33;
    localparam logic [5:0] HDR_LAST     = 6'd53;

    localparam logic [7:0] CHAR_B       = 8'h42;
    localparam logic [7:0] CHAR_M       = 8'h4D;
    localparam logic [7:0] PLANES_ONE   = 8'd1;
    localparam logic [7:0] BPP_24       = 8'd24;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] column;
        logic [11:0] row;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic        last_pixel;
    } out_beat_t;

endpackage

### sv/bmp24_stream_parser.sv
// ---------------------------------------------------------------------------
// bmp24_stream_parser
// Parses an uncompressed 24-bit BMP byte stream into RGB pixel results.
// ---------------------------------------------------------------------------
//  channel   dir  payload               beat
//  s_        in   bsp_pkg::in_beat_t    one file byte, first_byte restarts
//  m_        out  bsp_pkg::out_beat_t   one header status or one pixel
//
// one byte per cycle while results drain: input register, combinational parse,
// result register; a result beat follows its byte through both registers
// bytes with no result (most header bytes, blue, green, padding) give no beat
// a stalled result beat holds the parse; the input register still takes one byte
// reset clears the parser to idle; bytes before the first mark are dropped
// ---------------------------------------------------------------------------
module bmp24_stream_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bsp_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output bsp_pkg::out_beat_t m_data
);

    logic               take;
    logic               beat_valid;
    bsp_pkg::in_beat_t  beat;
    logic               res_hit;
    bsp_pkg::out_beat_t res;

    bsp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .take       (take),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    bsp_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .beat    (beat),
        .res_hit (res_hit),
        .res     (res)
    );

    bsp_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .beat_valid (beat_valid),
        .res_hit    (res_hit),
        .res        (res),
        .take       (take),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

### sv/bsp_in_stage.sv
// ---------------------------------------------------------------------------
// bsp_in_stage
// Input register: holds one byte beat until the parser takes it.
// ---------------------------------------------------------------------------
module bsp_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bsp_pkg::in_beat_t s_data,
    input  logic              take,
    output logic              beat_valid,
    output bsp_pkg::in_beat_t beat
);

    logic              valid_reg;
    bsp_pkg::in_beat_t data_reg;

    assign s_ready    = !valid_reg || take;
    assign beat_valid = valid_reg;
    assign beat       = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (take) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

endmodule

### sv/bsp_parser.sv
// ---------------------------------------------------------------------------
// bsp_parser
// Header checks, size assembly, pixel triple assembly and padding skip.
// ---------------------------------------------------------------------------
module bsp_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               take,
    input  bsp_pkg::in_beat_t  beat,
    output logic               res_hit,
    output bsp_pkg::out_beat_t res
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PIXELS,
        PH_PAD,
        PH_DONE
    } phase_t;

    localparam int unsigned CW = bsp_pkg::CNT_W;

    phase_t          phase_reg,   phase_next;
    logic [5:0]      index_reg,   index_next;
    logic            fmt_reg,     fmt_next;
    logic [31:0]     width_reg,   width_next;
    logic [31:0]     height_reg,  height_next;
    logic [CW-1:0]   col_reg,     col_next;
    logic [CW-1:0]   row_reg,     row_next;
    logic [1:0]      chan_reg,    chan_next;
    logic [7:0]      blue_reg,    blue_next;
    logic [7:0]      green_reg,   green_next;
    logic [1:0]      pad_reg,     pad_next;

    phase_t          cur_phase;
    logic [5:0]      cur_index;
    logic            cur_fmt;
    logic [31:0]     cur_width;
    logic [31:0]     cur_height;
    logic [7:0]      b;
    logic [CW-1:0]   col_inc;
    logic [CW-1:0]   row_inc;
    logic            last;

    always_comb begin
        b = beat.data_byte;
        // a first-byte mark restarts the header
        if (beat.first_byte) begin
            cur_phase  = PH_HEADER;
            cur_index  = '0;
            cur_fmt    = 1'b0;
            cur_width  = '0;
            cur_height = '0;
        end else begin
            cur_phase  = phase_reg;
            cur_index  = index_reg;
            cur_fmt    = fmt_reg;
            cur_width  = width_reg;
            cur_height = height_reg;
        end

        col_inc = col_reg + 1'b1;
        row_inc = row_reg + 1'b1;
        last    = (col_inc == width_reg[CW-1:0]) && (row_inc == height_reg[CW-1:0]);

        phase_next  = cur_phase;
        index_next  = cur_index;
        fmt_next    = cur_fmt;
        width_next  = cur_width;
        height_next = cur_height;
        col_next    = col_reg;
        row_next    = row_reg;
        chan_next   = chan_reg;
        blue_next   = blue_reg;
        green_next  = green_reg;
        pad_next    = pad_reg;

        res_hit = 1'b0;
        res     = '0;

        unique case (cur_phase)
            PH_HEADER: begin
                if ((cur_index == bsp_pkg::HDR_SIG0 && b != bsp_pkg::CHAR_B) ||
                    (cur_index == bsp_pkg::HDR_SIG1 && b != bsp_pkg::CHAR_M)) begin
                    res_hit         = 1'b1;
                    res.result_kind = bsp_pkg::KIND_BAD_SIG;
                    phase_next      = PH_DONE;
                end else begin
                    // little-endian size bytes, each written once after restart
                    if (cur_index >= bsp_pkg::HDR_WIDTH0 && cur_index <= bsp_pkg::HDR_WIDTH3) begin
                        width_next[8*(cur_index - bsp_pkg::HDR_WIDTH0) +: 8] = b;
                    end
                    if (cur_index >= bsp_pkg::HDR_HEIGHT0 &&
                        cur_index <= bsp_pkg::HDR_HEIGHT3) begin
                        height_next[8*(cur_index - bsp_pkg::HDR_HEIGHT0) +: 8] = b;
                    end
                    if ((cur_index == bsp_pkg::HDR_PLANES && b != bsp_pkg::PLANES_ONE) ||
                        (cur_index == bsp_pkg::HDR_BPP && b != bsp_pkg::BPP_24) ||
                        (cur_index >= bsp_pkg::HDR_COMP0 &&
                         cur_index <= bsp_pkg::HDR_COMP3 && b != 8'd0)) begin
                        fmt_next = 1'b1;
                    end

                    if (cur_index != bsp_pkg::HDR_LAST) begin
                        index_next = cur_index + 1'b1;
                    end else if (fmt_next) begin
                        res_hit         = 1'b1;
                        res.result_kind = bsp_pkg::KIND_BAD_FMT;
                        phase_next      = PH_DONE;
                    end else if (width_next > bsp_pkg::DIM_LIMIT ||
                                 height_next > bsp_pkg::DIM_LIMIT) begin
                        res_hit         = 1'b1;
                        res.result_kind = bsp_pkg::KIND_TOO_BIG;
                        phase_next      = PH_DONE;
                    end else begin
                        res_hit          = 1'b1;
                        res.result_kind  = bsp_pkg::KIND_HEADER;
                        res.image_width  = 13'(width_next);
                        res.image_height = 13'(height_next);
                        if (width_next == '0 || height_next == '0) begin
                            phase_next = PH_DONE;
                        end else begin
                            phase_next = PH_PIXELS;
                            col_next   = '0;
                            row_next   = '0;
                            chan_next  = '0;
                        end
                    end
                end
            end
            PH_PIXELS: begin
                if (chan_reg == 2'd0) begin
                    blue_next = b;
                    chan_next = 2'd1;
                end else if (chan_reg == 2'd1) begin
                    green_next = b;
                    chan_next  = 2'd2;
                end else begin
                    chan_next       = 2'd0;
                    res_hit         = 1'b1;
                    res.result_kind = bsp_pkg::KIND_PIXEL;
                    res.red         = b;
                    res.green       = green_reg;
                    res.blue        = blue_reg;
                    res.column      = 12'(col_reg);
                    res.row         = 12'(row_reg);
                    res.last_pixel  = last;
                    if (col_inc == width_reg[CW-1:0]) begin
                        col_next = '0;
                        row_next = row_inc;
                        if (last) begin
                            phase_next = PH_DONE;
                        end else if (width_reg[1:0] != 2'd0) begin
                            pad_next   = width_reg[1:0];
                            phase_next = PH_PAD;
                        end
                    end else begin
                        col_next = col_inc;
                    end
                end
            end
            PH_PAD: begin
                if (pad_reg != 2'd0) begin
                    pad_next = pad_reg - 1'b1;
                end
                if (pad_next == 2'd0) begin
                    phase_next = PH_PIXELS;
                end
            end
            PH_IDLE, PH_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            index_reg  <= '0;
            fmt_reg    <= 1'b0;
            width_reg  <= '0;
            height_reg <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            chan_reg   <= '0;
            blue_reg   <= '0;
            green_reg  <= '0;
            pad_reg    <= '0;
        end else if (take) begin
            phase_reg  <= phase_next;
            index_reg  <= index_next;
            fmt_reg    <= fmt_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            chan_reg   <= chan_next;
            blue_reg   <= blue_next;
            green_reg  <= green_next;
            pad_reg    <= pad_next;
        end
    end

    // a last pixel always ends the image
    assert property (@(posedge aclk) disable iff (!aresetn)
        (take && res_hit && res.result_kind == bsp_pkg::KIND_PIXEL && res.last_pixel)
        |=> phase_reg == PH_DONE)
        else $error("phase not done after last pixel");

    // triple assembly never reaches a fourth channel
    assert property (@(posedge aclk) disable iff (!aresetn) chan_reg != 2'd3)
        else $error("channel index out of range");

    // pixel phases only run with a checked, nonzero size
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PIXELS || phase_reg == PH_PAD) |->
        (width_reg != '0 && height_reg != '0 &&
         width_reg <= bsp_pkg::DIM_LIMIT && height_reg <= bsp_pkg::DIM_LIMIT))
        else $error("pixel phase with bad image size");

    // padding phase always has bytes left to skip
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAD |-> pad_reg != 2'd0)
        else $error("padding phase with empty count");

endmodule

### sv/bsp_out_stage.sv
// ---------------------------------------------------------------------------
// bsp_out_stage
// Result register: captures a result beat and holds it until taken.
// ---------------------------------------------------------------------------
module bsp_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               beat_valid,
    input  logic               res_hit,
    input  bsp_pkg::out_beat_t res,
    output logic               take,
    output logic               m_valid,
    input  logic               m_ready,
    output bsp_pkg::out_beat_t m_data
);

    logic               valid_reg;
    bsp_pkg::out_beat_t data_reg;

    // a held item advances once the result register is free or draining
    assign take    = beat_valid && (!valid_reg || m_ready);
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (take) begin
            valid_reg <= res_hit;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && res_hit) begin
            data_reg <= res;
        end
    end

endmodule

### tb/sv/bmp_pixel_checker.sv
// ---------------------------------------------------------------------------
// bmp_pixel_checker
// Watches both channels of the BMP stream parser, predicts the header status
// and pixel beats from every accepted byte, and compares them in order.
// ---------------------------------------------------------------------------
module bmp_pixel_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  bsp_pkg::in_beat_t  s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  bsp_pkg::out_beat_t m_data,
    output int                 fail_count,
    output int                 results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        PARSE_IDLE,
        PARSE_HEADER,
        PARSE_PIXELS,
        PARSE_PAD,
        PARSE_DONE
    } parse_phase_t;

    parse_phase_t phase;
    logic [5:0]   hdr_pos;
    logic         fmt_bad;
    logic [31:0]  width_acc;
    logic [31:0]  height_acc;
    logic [31:0]  col_cnt;
    logic [31:0]  row_cnt;
    logic [1:0]   chan_idx;
    logic [7:0]   blue_hold;
    logic [7:0]   green_hold;
    logic [1:0]   pad_cnt;

    bsp_pkg::out_beat_t parse_results_q[$];
    int                 mismatches = 0;

    task restart_parse();
        hdr_pos    = '0;
        fmt_bad    = 1'b0;
        width_acc  = '0;
        height_acc = '0;
        col_cnt    = '0;
        row_cnt    = '0;
        chan_idx   = '0;
        blue_hold  = '0;
        green_hold = '0;
        pad_cnt    = '0;
    endtask

    task report_mismatch(input string what);
        if (mismatches < 100) begin
            $display("%0t ns bmp24 check: %s", $time, what);
        end
        mismatches++;
    endtask

    task check_field(input string name, input logic [31:0] got, input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    task parse_byte(input bsp_pkg::in_beat_t beat);
        bsp_pkg::out_beat_t res;
        logic [7:0]         b;
        logic [5:0]         k;
        logic               last;
        b   = beat.data_byte;
        res = '0;
        if (beat.first_byte) begin
            restart_parse();
            phase = PARSE_HEADER;
        end
        case (phase)
            PARSE_HEADER: begin
                k = hdr_pos;
                if ((k == bsp_pkg::HDR_SIG0 && b != bsp_pkg::CHAR_B) ||
                    (k == bsp_pkg::HDR_SIG1 && b != bsp_pkg::CHAR_M)) begin
                    res.result_kind = bsp_pkg::KIND_BAD_SIG;
                    parse_results_q.push_back(res);
                    phase = PARSE_DONE;
                end else begin
                    if (k >= bsp_pkg::HDR_WIDTH0 && k <= bsp_pkg::HDR_WIDTH3) begin
                        width_acc[8 * (k - bsp_pkg::HDR_WIDTH0) +: 8] = b;
                    end
                    if (k >= bsp_pkg::HDR_HEIGHT0 && k <= bsp_pkg::HDR_HEIGHT3) begin
                        height_acc[8 * (k - bsp_pkg::HDR_HEIGHT0) +: 8] = b;
                    end
                    if ((k == bsp_pkg::HDR_PLANES && b != bsp_pkg::PLANES_ONE) ||
                        (k == bsp_pkg::HDR_BPP && b != bsp_pkg::BPP_24) ||
                        (k >= bsp_pkg::HDR_COMP0 && k <= bsp_pkg::HDR_COMP3 &&
                         b != 8'h00)) begin
                        fmt_bad = 1'b1;
                    end
                    if (k != bsp_pkg::HDR_LAST) begin
                        hdr_pos = k + 6'd1;
                    end else if (fmt_bad) begin
                        res.result_kind = bsp_pkg::KIND_BAD_FMT;
                        parse_results_q.push_back(res);
                        phase = PARSE_DONE;
                    end else if (width_acc > bsp_pkg::DIM_LIMIT ||
                                 height_acc > bsp_pkg::DIM_LIMIT) begin
                        res.result_kind = bsp_pkg::KIND_TOO_BIG;
                        parse_results_q.push_back(res);
                        phase = PARSE_DONE;
                    end else begin
                        res.result_kind  = bsp_pkg::KIND_HEADER;
                        res.image_width  = width_acc[12:0];
                        res.image_height = height_acc[12:0];
                        parse_results_q.push_back(res);
                        // an empty image has no pixel data
                        if (width_acc == 0 || height_acc == 0) begin
                            phase = PARSE_DONE;
                        end else begin
                            phase    = PARSE_PIXELS;
                            col_cnt  = '0;
                            row_cnt  = '0;
                            chan_idx = '0;
                        end
                    end
                end
            end
            PARSE_PIXELS: begin
                if (chan_idx == 2'd0) begin
                    blue_hold = b;
                    chan_idx  = 2'd1;
                end else if (chan_idx == 2'd1) begin
                    green_hold = b;
                    chan_idx   = 2'd2;
                end else begin
                    chan_idx = 2'd0;
                    last = (col_cnt + 1 == width_acc) && (row_cnt + 1 == height_acc);
                    res.result_kind = bsp_pkg::KIND_PIXEL;
                    res.red         = b;
                    res.green       = green_hold;
                    res.blue        = blue_hold;
                    res.column      = col_cnt[11:0];
                    res.row         = row_cnt[11:0];
                    res.last_pixel  = last;
                    parse_results_q.push_back(res);
                    col_cnt = col_cnt + 1;
                    if (col_cnt == width_acc) begin
                        col_cnt = '0;
                        row_cnt = row_cnt + 1;
                        if (last) begin
                            phase = PARSE_DONE;
                        end else if (width_acc[1:0] != 2'd0) begin
                            // rows are padded to a multiple of four bytes
                            pad_cnt = width_acc[1:0];
                            phase   = PARSE_PAD;
                        end
                    end
                end
            end
            PARSE_PAD: begin
                if (pad_cnt != 2'd0) begin
                    pad_cnt = pad_cnt - 2'd1;
                end
                if (pad_cnt == 2'd0) begin
                    phase = PARSE_PIXELS;
                end
            end
            default: begin
            end
        endcase
    endtask

    task check_result(input bsp_pkg::out_beat_t got);
        bsp_pkg::out_beat_t want;
        if (parse_results_q.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing expected, kind %0d",
                                      got.result_kind));
        end else begin
            want = parse_results_q.pop_front();
            check_field("result_kind", 32'(got.result_kind), 32'(want.result_kind));
            check_field("red", 32'(got.red), 32'(want.red));
            check_field("green", 32'(got.green), 32'(want.green));
            check_field("blue", 32'(got.blue), 32'(want.blue));
            check_field("column", 32'(got.column), 32'(want.column));
            check_field("row", 32'(got.row), 32'(want.row));
            check_field("image_width", 32'(got.image_width), 32'(want.image_width));
            check_field("image_height", 32'(got.image_height), 32'(want.image_height));
            check_field("last_pixel", 32'(got.last_pixel), 32'(want.last_pixel));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            restart_parse();
            phase = PARSE_IDLE;
            parse_results_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                parse_byte(s_data);
            end
            if (m_valid && m_ready) begin
                check_result(m_data);
            end
        end
        results_due <= parse_results_q.size();
        fail_count  <= mismatches;
    end

endmodule

### tb/sv/tb.sv
// ---------------------------------------------------------------------------
// tb
// Byte stream stimulus for the 24-bit BMP parser: directed headers, errors
// and size extremes, then random small files with broken ones mixed in.
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    bsp_pkg::in_beat_t  s_data  = '0;
    logic               s_ready;
    logic               m_valid;
    logic               m_ready = 1'b0;
    bsp_pkg::out_beat_t m_data;
    int                 fail_count;
    int                 results_due;

    logic       quiet_link    = 1'b0;
    int         hold_requests = 0;
    int         parsed_bytes  = 0;
    logic [7:0] file_hdr [54];

    always #2 aclk = ~aclk;

    bmp24_stream_parser dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    bmp_pixel_checker pixel_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .fail_count  (fail_count),
        .results_due (results_due)
    );

    task send_byte(input logic [7:0] value, input logic mark);
        bsp_pkg::in_beat_t beat;
        beat.data_byte  = value;
        beat.first_byte = mark;
        while (!quiet_link && $urandom_range(0, 99) < 37) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task send_junk(input int n);
        int i;
        for (i = 0; i < n; i++) begin
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    task make_header(input logic [31:0] w, input logic [31:0] h);
        int i;
        for (i = 0; i < 54; i++) begin
            file_hdr[i] = 8'($urandom_range(0, 255));
        end
        file_hdr[bsp_pkg::HDR_SIG0]   = bsp_pkg::CHAR_B;
        file_hdr[bsp_pkg::HDR_SIG1]   = bsp_pkg::CHAR_M;
        file_hdr[bsp_pkg::HDR_PLANES] = bsp_pkg::PLANES_ONE;
        file_hdr[bsp_pkg::HDR_BPP]    = bsp_pkg::BPP_24;
        for (i = 0; i < 4; i++) begin
            file_hdr[bsp_pkg::HDR_WIDTH0 + i]  = w[8 * i +: 8];
            file_hdr[bsp_pkg::HDR_HEIGHT0 + i] = h[8 * i +: 8];
            file_hdr[bsp_pkg::HDR_COMP0 + i]   = 8'h00;
        end
    endtask

    task send_header(input int count);
        int i;
        for (i = 0; i < count; i++) begin
            send_byte(file_hdr[i], i == 0);
            parsed_bytes++;
        end
    endtask

    // stops after limit bytes so a file can be cut short
    task send_pixels(input int w, input int h, input int limit);
        int r;
        int c;
        int n;
        n = 0;
        for (r = 0; r < h; r++) begin
            for (c = 0; c < 3 * w + ((r != h - 1) ? w % 4 : 0); c++) begin
                if (n == limit) return;
                send_byte(8'($urandom_range(0, 255)), 1'b0);
                parsed_bytes++;
                n++;
            end
        end
    endtask

    task send_file(input int w, input int h);
        make_header(w, h);
        send_header(54);
        send_pixels(w, h, 1 << 30);
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin : result_sink
        int served;
        int cnt;
        served = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_requests != served) begin
                served = hold_requests;
                for (cnt = 0; cnt < 400; cnt++) begin
                    m_ready <= 1'b0;
                    @(posedge aclk);
                end
            end else begin
                m_ready <= quiet_link || ($urandom_range(0, 99) >= 37);
                @(posedge aclk);
            end
        end
    end

    initial begin : byte_source
        int j;
        int w;
        int h;
        int sel;
        int file_no;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // bytes before any mark are dropped
        send_junk(4);

        // one pixel image with channel extremes
        make_header(1, 1);
        send_header(54);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_junk(3);

        // every padding length
        send_file(3, 2);
        send_file(2, 3);
        send_file(4, 2);
        send_file(5, 2);

        // empty images
        send_file(0, 3);
        send_junk(6);
        send_file(7, 0);

        // signature errors
        make_header(2, 2);
        file_hdr[bsp_pkg::HDR_SIG0] = bsp_pkg::CHAR_M;
        send_header(54);
        make_header(2, 2);
        file_hdr[bsp_pkg::HDR_SIG1] = bsp_pkg::CHAR_B;
        send_header(54);

        // format errors, one per checked byte
        make_header(2, 2);
        file_hdr[bsp_pkg::HDR_PLANES] = 8'd0;
        send_header(54);
        make_header(2, 2);
        file_hdr[bsp_pkg::HDR_BPP] = 8'd32;
        send_header(54);
        for (j = 0; j < 4; j++) begin
            make_header(2, 2);
            file_hdr[bsp_pkg::HDR_COMP0 + j] = 8'h01 << j;
            send_header(54);
        end
        // bad format wins over too large
        make_header(5000, 2);
        file_hdr[bsp_pkg::HDR_PLANES] = 8'd2;
        send_header(54);

        // sizes above the limit, negative ones included
        make_header(4097, 1);
        send_header(54);
        make_header(1, 4097);
        send_header(54);
        make_header(32'hFFFF_FFFF, 2);
        send_header(54);
        make_header(3, 32'h8000_0000);
        send_header(54);
        make_header(32'h0001_0000, 1);
        send_header(54);

        // largest accepted size, cut short by the next file
        make_header(4096, 4096);
        send_header(54);
        send_pixels(4096, 4096, 30);

        // restart inside the header and inside the pixel data
        make_header(2, 2);
        send_header(20);
        send_file(3, 1);
        make_header(4, 3);
        send_header(54);
        send_pixels(4, 3, 17);
        send_file(1, 2);

        parsed_bytes = 0;
        file_no      = 0;
        while (parsed_bytes < 500) begin
            quiet_link <= (file_no >= 1 && file_no < 4);
            sel = $urandom_range(0, 99);
            w   = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 9);
            h   = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 5);
            if (file_no == 0) begin
                // stall the results long enough to back up the input
                hold_requests <= hold_requests + 1;
                sel = 0;
                w   = 8;
                h   = 6;
            end
            if (sel < 65) begin
                send_file(w, h);
            end else if (sel < 80) begin
                make_header(w, h);
                case ($urandom_range(0, 6))
                    0: file_hdr[bsp_pkg::HDR_SIG0] ^= 8'($urandom_range(1, 255));
                    1: file_hdr[bsp_pkg::HDR_SIG1] ^= 8'($urandom_range(1, 255));
                    2: file_hdr[bsp_pkg::HDR_PLANES] ^= 8'($urandom_range(1, 255));
                    3: file_hdr[bsp_pkg::HDR_BPP] ^= 8'($urandom_range(1, 255));
                    4: file_hdr[bsp_pkg::HDR_COMP0 + $urandom_range(0, 3)] =
                           8'($urandom_range(1, 255));
                    5: file_hdr[bsp_pkg::HDR_WIDTH3] = 8'($urandom_range(1, 255));
                    default: make_header(w, 4097);
                endcase
                send_header(54);
                send_junk($urandom_range(0, 5));
            end else if (sel < 90) begin
                make_header(w, h);
                if ($urandom_range(0, 1) == 0) begin
                    send_header($urandom_range(1, 53));
                end else begin
                    send_header(54);
                    send_pixels(w, h, $urandom_range(0, 3 * w * h));
                end
            end else begin
                // stray marks and loose bytes
                if ($urandom_range(0, 2) == 0) begin
                    send_byte(8'($urandom_range(0, 255)), 1'b1);
                end
                send_junk($urandom_range(1, 10));
            end
            file_no++;
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && results_due == 0) begin
            $display("** bmp24_stream_parser: PASSED **");
        end else begin
            $display("** bmp24_stream_parser: FAILED **");
        end
        $finish;
    end

    initial begin : run_limit
        #4_000_000;
        $display("** bmp24_stream_parser: FAILED **");
        $finish;
    end

endmodule
